>>> design/mfcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcp_pkg: shared types and constants of the meter frame config parser
// Character codes, stream widths and the structs passed between stages.
// ----------------------------------------------------------------------------
package mfcp_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_FIVE   = 8'h35;

    localparam logic [7:0] METER_COUNT_RESET = 8'd16;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 1;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic        seen_dollar;
        logic        stopped;
        logic        in_first;
        logic [3:0]  char_pos;
        logic [7:0]  tag_char;
        logic [7:0]  frame_digit;
        logic [7:0]  id_first;
        logic [15:0] start_acc;
        logic [15:0] count_acc;
        logic [7:0]  cur_meter;
        logic [1:0]  frames_seen;
        logic        locked;
    } parse_state_t;

    // Results caused by one input word: an optional table write, then an
    // optional end-of-message word.
    typedef struct packed {
        logic        has_frame;
        logic [7:0]  meter_slot;
        logic [2:0]  frame_slot;
        logic [15:0] start_address;
        logic [15:0] data_count;
        logic        write_frame_count;
        logic [2:0]  frame_count;
        logic        has_done;
        logic [7:0]  next_meter;
    } result_pair_t;

endpackage

>>> design/mfcp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcp_parser: per-byte parse step
// Holds the parse state and works out, for each accepted byte, the next
// state and the result words that byte causes.
// ----------------------------------------------------------------------------
module mfcp_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_accept,
    input  logic [7:0]             rx_byte,
    input  logic                   end_of_message,
    input  logic [7:0]             meter_count,
    output logic                   push,
    output mfcp_pkg::result_pair_t push_pair
);
    import mfcp_pkg::*;

    // Idle parse state: waiting for '$', first token next
    localparam parse_state_t STATE_RESET = '{
        seen_dollar: 1'b0,
        stopped:     1'b0,
        in_first:    1'b1,
        char_pos:    4'd0,
        tag_char:    8'd0,
        frame_digit: 8'd0,
        id_first:    8'd0,
        start_acc:   16'd0,
        count_acc:   16'd0,
        cur_meter:   8'd0,
        frames_seen: 2'd0,
        locked:      1'b0
    };

    parse_state_t state_reg;
    parse_state_t state_next;

    function automatic logic [7:0] x10_8(input logic [7:0] x);
        x10_8 = {x[4:0], 3'b000} + {x[6:0], 1'b0};
    endfunction

    function automatic logic [15:0] x10_16(input logic [15:0] x);
        x10_16 = {x[12:0], 3'b000} + {x[14:0], 1'b0};
    endfunction

    function automatic parse_state_t take_char(input parse_state_t s,
                                               input logic [7:0] c,
                                               input logic [7:0] mc);
        parse_state_t r;
        logic [7:0]   d;
        logic [7:0]   id;
        r  = s;
        d  = c - CH_ZERO;
        id = x10_8(s.id_first - CH_ZERO) + d;
        case (s.char_pos)
            4'd0:
            begin
                r.tag_char  = c;
                r.start_acc = '0;
                r.count_acc = '0;
            end
            4'd1:
            begin
                r.frame_digit = c;
                r.id_first    = c;
            end
            4'd2:
            begin
                if (s.in_first && id != 8'd0 && id <= mc)
                begin
                    r.cur_meter   = id;
                    r.frames_seen = 2'd0;
                    r.locked      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        // digit value wraps at 16 bits, so a character below '0' subtracts
        if (s.char_pos >= 4'd3 && s.char_pos <= 4'd7)
            r.start_acc = x10_16(s.start_acc) + {8'd0, c} - {8'd0, CH_ZERO};
        if (s.char_pos >= 4'd9 && s.char_pos <= 4'd13)
            r.count_acc = x10_16(s.count_acc) + {8'd0, c} - {8'd0, CH_ZERO};
        if (s.char_pos != 4'd15)
            r.char_pos = s.char_pos + 4'd1;
        return r;
    endfunction

    function automatic parse_state_t end_token(input  parse_state_t s,
                                               input  logic [7:0]   mc,
                                               output logic         hit,
                                               output logic [2:0]   fk,
                                               output logic         wfc);
        parse_state_t r;
        r   = s;
        hit = 1'b0;
        fk  = s.frame_digit[2:0] - 3'd0;
        wfc = 1'b0;
        if (s.in_first)
            r.in_first = 1'b0;
        else if (s.char_pos >= 4'd14 && s.tag_char == CH_F
                 && s.frame_digit >= CH_ONE && s.frame_digit <= CH_FIVE
                 && s.cur_meter != 8'd0 && s.cur_meter <= mc)
        begin
            hit = 1'b1;
            fk  = s.frame_digit[2:0];  // '1'..'5' low bits are 1..5
            if (fk == 3'd1 && s.frames_seen != 2'd0)
                r.locked = 1'b1;
            if (s.frames_seen != 2'd2)
                r.frames_seen = s.frames_seen + 2'd1;
            wfc = ~r.locked;
        end
        r.char_pos = 4'd0;
        return r;
    endfunction

    always_comb
    begin
        parse_state_t s1;
        logic         hit_a;
        logic         hit_b;
        logic [2:0]   fk_a;
        logic [2:0]   fk_b;
        logic         wfc_a;
        logic         wfc_b;

        s1    = state_reg;
        hit_a = 1'b0;
        hit_b = 1'b0;
        fk_a  = 3'd0;
        fk_b  = 3'd0;
        wfc_a = 1'b0;
        wfc_b = 1'b0;

        if (!state_reg.stopped)
        begin
            if (rx_byte == 8'd0)
            begin
                if (state_reg.seen_dollar)
                    s1 = end_token(s1, meter_count, hit_a, fk_a, wfc_a);
                s1.stopped = 1'b1;
            end
            else if (!state_reg.seen_dollar)
            begin
                if (rx_byte == CH_DOLLAR)
                begin
                    s1.seen_dollar = 1'b1;
                    s1 = take_char(s1, rx_byte, meter_count);
                end
            end
            else if (rx_byte == CH_COMMA)
                s1 = end_token(s1, meter_count, hit_a, fk_a, wfc_a);
            else
                s1 = take_char(s1, rx_byte, meter_count);
        end

        if (end_of_message)
        begin
            if (s1.seen_dollar && !s1.stopped)
                s1 = end_token(s1, meter_count, hit_b, fk_b, wfc_b);
            s1.seen_dollar = 1'b0;
            s1.stopped     = 1'b0;
            s1.in_first    = 1'b1;
            s1.char_pos    = 4'd0;
        end

        state_next = s1;

        // At most one of the two token ends can hit within one byte
        push_pair.has_frame         = hit_a | hit_b;
        push_pair.meter_slot        = s1.cur_meter - 8'd1;
        push_pair.frame_slot        = (hit_a ? fk_a : fk_b) - 3'd1;
        push_pair.start_address     = s1.start_acc;
        push_pair.data_count        = s1.count_acc;
        push_pair.write_frame_count = hit_a ? wfc_a : wfc_b;
        push_pair.frame_count       = hit_a ? fk_a : fk_b;
        push_pair.has_done          = end_of_message;
        push_pair.next_meter        = (s1.cur_meter >= meter_count)
                                      ? 8'd1 : s1.cur_meter + 8'd1;
        push = in_accept & (hit_a | hit_b | end_of_message);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (in_accept)
            state_reg <= state_next;
    end

endmodule

>>> design/mfcp_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcp_out_queue: two-entry result queue and word serializer
// Stores result pairs and sends them out one word per handshake.
// ----------------------------------------------------------------------------
module mfcp_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mfcp_pkg::result_pair_t push_pair,
    output logic                   not_full,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [mfcp_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [mfcp_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                   m_tlast
);
    import mfcp_pkg::*;

    result_pair_t mem [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic         half_reg;    // frame word of head entry already sent
    result_pair_t head;
    logic         send_frame;
    logic         pop;
    logic         take;

    assign head       = mem[rd_ptr_reg];
    assign send_frame = head.has_frame & ~half_reg;
    assign m_tvalid   = cnt_reg != 2'd0;
    assign take       = m_tvalid & m_tready;
    assign pop        = take & (~send_frame | ~head.has_done);
    assign not_full   = cnt_reg != 2'd2;

    always_comb
    begin
        m_tdata = '0;
        if (send_frame)
        begin
            m_tdata[7:0]   = head.meter_slot;
            m_tdata[10:8]  = head.frame_slot;
            m_tdata[26:11] = head.start_address;
            m_tdata[42:27] = head.data_count;
            m_tdata[43]    = head.write_frame_count;
            m_tdata[46:44] = head.frame_count;
            m_tuser        = KIND_FRAME;
            m_tlast        = 1'b0;
        end
        else
        begin
            m_tdata[54:47] = head.next_meter;
            m_tuser        = KIND_DONE;
            m_tlast        = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            half_reg   <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (pop)
                half_reg <= 1'b0;
            else if (take)
                half_reg <= 1'b1;
        end
    end

endmodule

>>> design/meter_frame_config_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_frame_config_parser: turns meter config messages into table writes
// Top level: config register, byte parser and output queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one message byte per word in s_tdata, s_tlast on the
//   last byte of the message. One byte is taken per cycle while s_tready.
//   Output stream (m_*): m_tuser is the kind (0 table write, 1 message
//   finished). A message ends with exactly one kind 1 word, with m_tlast
//   set and the next meter id to poll.
//   cfg_we/cfg_wdata write meter_count; write it only while the block idles.
// Output: each taken byte's results enter the result queue and leave it
//   in order. A byte yields zero, one or two words.
// Throughput: one byte per cycle while s_tready is high. A byte that yields
//   two words (a table write and the end word) takes two output handshakes;
//   the two-entry result queue absorbs this; s_tready drops only when full.
// Reset: parse state cleared, current meter 0, meter_count 16, queue empty.
// Stall: with m_tready low, up to two pending byte results queue; then
//   s_tready goes low until a queue entry drains.
// ----------------------------------------------------------------------------
module meter_frame_config_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: [7:0] rx_byte; s_tlast: end_of_message
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mfcp_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    // m_tdata: [7:0] meter_slot, [10:8] frame_slot, [26:11] start_address,
    //          [42:27] data_count, [43] write_frame_count,
    //          [46:44] frame_count, [54:47] next_meter, [55] zero
    // m_tuser: [0] kind; m_tlast: last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mfcp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [mfcp_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast,
    // meter_count register
    input  logic                                cfg_we,
    input  logic [7:0]                          cfg_wdata
);
    import mfcp_pkg::*;

    logic [7:0]   meter_count_reg;
    logic         in_accept;
    logic         push;
    result_pair_t push_pair;
    logic         not_full;

    // Queue has room for one more byte's results
    assign s_tready  = not_full;
    assign in_accept = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            meter_count_reg <= METER_COUNT_RESET;
        else if (cfg_we)
            meter_count_reg <= cfg_wdata;
    end

    // Parse state updates on every taken byte
    mfcp_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_accept      (in_accept),
        .rx_byte        (s_tdata),
        .end_of_message (s_tlast),
        .meter_count    (meter_count_reg),
        .push           (push),
        .push_pair      (push_pair)
    );

    // Results leave one word per handshake
    mfcp_out_queue u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_pair (push_pair),
        .not_full  (not_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> design/mfcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcp_checker: port-level checks of the meter frame config parser
// Watches the output stream for held words and consistent result fields.
// ----------------------------------------------------------------------------
module mfcp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [mfcp_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic [mfcp_pkg::OUT_USER_W-1:0]     m_tuser,
    input logic                                m_tlast
);
    import mfcp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == KIND_DONE |->
            m_tlast && m_tdata[46:0] == '0 && m_tdata[54:47] != 8'd0)
        else $error("end word carries table fields or no next meter");

    a_frame_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == KIND_FRAME |->
            !m_tlast && m_tdata[54:47] == 8'd0 && m_tdata[7:0] != 8'd255)
        else $error("table write word marked last or carries next meter");

    a_frame_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == KIND_FRAME |->
            m_tdata[10:8] <= 3'd4 && m_tdata[46:44] == m_tdata[10:8] + 3'd1)
        else $error("frame slot and frame count disagree");

endmodule

bind meter_frame_config_parser mfcp_checker u_mfcp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
